// ===== sv/hv_contactor_charge_sequencer_core_defines.svh =====
// ----------------------------------------------------------------------------
// hv_contactor_charge_sequencer_core_defines.svh
// assertion macros shared by the sequencer checker
// ----------------------------------------------------------------------------
`ifndef HV_CONTACTOR_CHARGE_SEQUENCER_CORE_DEFINES_SVH
`define HV_CONTACTOR_CHARGE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define HCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hv sequencer check failed");

// next-cycle implication
`define HCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hv sequencer check failed");

`endif

// ===== sv/hcs_pkg.sv =====
// ----------------------------------------------------------------------------
// hcs_pkg
// state, mode and register codes plus shared types for the hv sequencer
// ----------------------------------------------------------------------------
package hcs_pkg;

  localparam int unsigned HV_W   = 20;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned ST_W   = 4;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned IDX_W  = 3;

  // sequencer states
  localparam logic [ST_W-1:0] ST_ERROR     = 4'd0;
  localparam logic [ST_W-1:0] ST_DISCHARGE = 4'd1;
  localparam logic [ST_W-1:0] ST_STANDBY   = 4'd2;
  localparam logic [ST_W-1:0] ST_DRV_PRE   = 4'd3;
  localparam logic [ST_W-1:0] ST_DRV_PREOK = 4'd4;
  localparam logic [ST_W-1:0] ST_DRIVE     = 4'd5;
  localparam logic [ST_W-1:0] ST_CHG_PRE   = 4'd6;
  localparam logic [ST_W-1:0] ST_CHG_PREOK = 4'd7;
  localparam logic [ST_W-1:0] ST_TRICKLE   = 4'd8;
  localparam logic [ST_W-1:0] ST_CC        = 4'd9;
  localparam logic [ST_W-1:0] ST_CV        = 4'd10;
  localparam logic [ST_W-1:0] ST_CLEAR     = 4'd11;
  localparam logic [ST_W-1:0] ST_UNKNOWN   = 4'd12;

  // requested modes
  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RUN    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHARGE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ACK    = 3'd4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_DISCHARGED_LIMIT = 3'd0;
  localparam logic [IDX_W-1:0] REG_DRIVE_MATCH      = 3'd1;
  localparam logic [IDX_W-1:0] REG_DRIVE_MIN_BUS    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CHARGE_MATCH     = 3'd3;
  localparam logic [IDX_W-1:0] REG_CHARGE_CLOSE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRICKLE_EXIT     = 3'd5;
  localparam logic [IDX_W-1:0] REG_CC_EXIT          = 3'd6;
  localparam logic [IDX_W-1:0] REG_CV_DONE          = 3'd7;

  // register reset values
  localparam logic [HV_W-1:0]   RST_DISCHARGED_LIMIT = 20'd5000;
  localparam logic [HV_W-1:0]   RST_DRIVE_MATCH      = 20'd30000;
  localparam logic [HV_W-1:0]   RST_DRIVE_MIN_BUS    = 20'd10000;
  localparam logic [HV_W-1:0]   RST_CHARGE_MATCH     = 20'd25000;
  localparam logic [HV_W-1:0]   RST_CHARGE_CLOSE     = 20'd5000;
  localparam logic [CELL_W-1:0] RST_TRICKLE_EXIT     = 16'd3000;
  localparam logic [CELL_W-1:0] RST_CC_EXIT          = 16'd4150;
  localparam logic [CELL_W-1:0] RST_CV_DONE          = 16'd4145;

  typedef struct packed {
    logic [HV_W-1:0]   discharged_limit_mv;
    logic [HV_W-1:0]   drive_match_mv;
    logic [HV_W-1:0]   drive_min_bus_mv;
    logic [HV_W-1:0]   charge_match_mv;
    logic [HV_W-1:0]   charge_close_mv;
    logic [CELL_W-1:0] trickle_exit_cell_mv;
    logic [CELL_W-1:0] cc_exit_cell_mv;
    logic [CELL_W-1:0] cv_done_cell_mv;
  } cfg_regs_t;

  typedef struct packed {
    logic [ST_W-1:0] held_state;
    logic [ST_W-1:0] next_state;
    logic            air_pos_closed;
    logic            air_neg_closed;
    logic            precharge_closed;
    logic            discharge_closed;
    logic            clear_fault;
    logic            clear_error_reg;
  } step_res_t;

endpackage

// ===== sv/hv_contactor_charge_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// hv_contactor_charge_sequencer_core
// high-voltage contactor and charge sequencer, one step per item
// ----------------------------------------------------------------------------
// usage:
//   input channel in_*: one item per sequencer tick (error flag, requested
//   mode, bus and battery voltage, lowest and highest cell voltage).
//   result channel out_*: the state held at the start of the tick, the next
//   state, and the relay levels and fault-clear pulses of the held state.
//   cfg_*: threshold registers, to be written only while the block is idle;
//   the block itself does not enforce this.
// flow: an accepted item waits in the input register and moves into the
//   result register once that register is free to take it.
// throughput: one item per cycle when not stalled; the state register is
//   updated as an item moves from the input register to the result register.
// reset: state returns to error, thresholds to their defaults, both
//   registers empty.
// stall: a stalled result holds; the input register still takes one item,
//   after which in_stall follows out_stall.
// ----------------------------------------------------------------------------
module hv_contactor_charge_sequencer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic [hcs_pkg::IDX_W-1:0]  cfg_idx,
  input  logic [hcs_pkg::HV_W-1:0]   cfg_data,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_error_active,
  input  logic [hcs_pkg::MODE_W-1:0] in_mode_request,
  input  logic [hcs_pkg::HV_W-1:0]   in_bus_mv,
  input  logic [hcs_pkg::HV_W-1:0]   in_battery_mv,
  input  logic [hcs_pkg::CELL_W-1:0] in_min_cell_mv,
  input  logic [hcs_pkg::CELL_W-1:0] in_max_cell_mv,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hcs_pkg::ST_W-1:0]   out_held_state,
  output logic [hcs_pkg::ST_W-1:0]   out_next_state,
  output logic                       out_air_pos_closed,
  output logic                       out_air_neg_closed,
  output logic                       out_precharge_closed,
  output logic                       out_discharge_closed,
  output logic                       out_clear_fault,
  output logic                       out_clear_error_reg
);

  hcs_pkg::cfg_regs_t  cfg_r;
  hcs_pkg::cfg_regs_t  cfg_nxt;
  logic [hcs_pkg::ST_W-1:0] state_r;
  logic [hcs_pkg::ST_W-1:0] state_nxt;

  logic                       s1_vld_r;
  logic                       s1_vld_nxt;
  logic                       s1_err_r;
  logic [hcs_pkg::MODE_W-1:0] s1_mode_r;
  logic [hcs_pkg::HV_W-1:0]   s1_bus_r;
  logic [hcs_pkg::HV_W-1:0]   s1_batt_r;
  logic [hcs_pkg::CELL_W-1:0] s1_cmin_r;
  logic [hcs_pkg::CELL_W-1:0] s1_cmax_r;

  logic               out_vld_r;
  logic               out_vld_nxt;
  hcs_pkg::step_res_t out_res_r;
  hcs_pkg::step_res_t step_res;

  logic out_free;
  logic advance;
  logic in_acc;

  assign out_free = !out_vld_r || !out_stall;
  assign advance  = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  hcs_step u_step (
    .held_state   (state_r),
    .error_active (s1_err_r),
    .mode_request (s1_mode_r),
    .bus_mv       (s1_bus_r),
    .battery_mv   (s1_batt_r),
    .min_cell_mv  (s1_cmin_r),
    .max_cell_mv  (s1_cmax_r),
    .cfg          (cfg_r),
    .res          (step_res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        hcs_pkg::REG_DISCHARGED_LIMIT: cfg_nxt.discharged_limit_mv  = cfg_data;
        hcs_pkg::REG_DRIVE_MATCH:      cfg_nxt.drive_match_mv       = cfg_data;
        hcs_pkg::REG_DRIVE_MIN_BUS:    cfg_nxt.drive_min_bus_mv     = cfg_data;
        hcs_pkg::REG_CHARGE_MATCH:     cfg_nxt.charge_match_mv      = cfg_data;
        hcs_pkg::REG_CHARGE_CLOSE:     cfg_nxt.charge_close_mv      = cfg_data;
        hcs_pkg::REG_TRICKLE_EXIT:     cfg_nxt.trickle_exit_cell_mv =
                                         cfg_data[hcs_pkg::CELL_W-1:0];
        hcs_pkg::REG_CC_EXIT:          cfg_nxt.cc_exit_cell_mv      =
                                         cfg_data[hcs_pkg::CELL_W-1:0];
        hcs_pkg::REG_CV_DONE:          cfg_nxt.cv_done_cell_mv      =
                                         cfg_data[hcs_pkg::CELL_W-1:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  assign state_nxt   = advance ? step_res.next_state : state_r;
  assign s1_vld_nxt  = in_acc ? 1'b1 : (advance ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = advance ? 1'b1 : (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.discharged_limit_mv  <= hcs_pkg::RST_DISCHARGED_LIMIT;
      cfg_r.drive_match_mv       <= hcs_pkg::RST_DRIVE_MATCH;
      cfg_r.drive_min_bus_mv     <= hcs_pkg::RST_DRIVE_MIN_BUS;
      cfg_r.charge_match_mv      <= hcs_pkg::RST_CHARGE_MATCH;
      cfg_r.charge_close_mv      <= hcs_pkg::RST_CHARGE_CLOSE;
      cfg_r.trickle_exit_cell_mv <= hcs_pkg::RST_TRICKLE_EXIT;
      cfg_r.cc_exit_cell_mv      <= hcs_pkg::RST_CC_EXIT;
      cfg_r.cv_done_cell_mv      <= hcs_pkg::RST_CV_DONE;
      state_r                    <= hcs_pkg::ST_ERROR;
      s1_vld_r                   <= 1'b0;
      out_vld_r                  <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      state_r   <= state_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_err_r  <= in_error_active;
      s1_mode_r <= in_mode_request;
      s1_bus_r  <= in_bus_mv;
      s1_batt_r <= in_battery_mv;
      s1_cmin_r <= in_min_cell_mv;
      s1_cmax_r <= in_max_cell_mv;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_held_state       = out_res_r.held_state;
  assign out_next_state       = out_res_r.next_state;
  assign out_air_pos_closed   = out_res_r.air_pos_closed;
  assign out_air_neg_closed   = out_res_r.air_neg_closed;
  assign out_precharge_closed = out_res_r.precharge_closed;
  assign out_discharge_closed = out_res_r.discharge_closed;
  assign out_clear_fault      = out_res_r.clear_fault;
  assign out_clear_error_reg  = out_res_r.clear_error_reg;

endmodule

// ===== sv/hcs_step.sv =====
// ----------------------------------------------------------------------------
// hcs_step
// one sequencer tick: relay levels for the held state and the next state
// ----------------------------------------------------------------------------
module hcs_step (
  input  logic [hcs_pkg::ST_W-1:0]   held_state,
  input  logic                       error_active,
  input  logic [hcs_pkg::MODE_W-1:0] mode_request,
  input  logic [hcs_pkg::HV_W-1:0]   bus_mv,
  input  logic [hcs_pkg::HV_W-1:0]   battery_mv,
  input  logic [hcs_pkg::CELL_W-1:0] min_cell_mv,
  input  logic [hcs_pkg::CELL_W-1:0] max_cell_mv,
  input  hcs_pkg::cfg_regs_t         cfg,
  output hcs_pkg::step_res_t         res
);

  logic [hcs_pkg::HV_W-1:0] diff;
  logic                     drive_mode;
  logic                     is_run;
  logic                     is_charge;
  logic [hcs_pkg::ST_W-1:0] nxt;

  // exact absolute difference, no wrap
  assign diff = (battery_mv >= bus_mv) ? (battery_mv - bus_mv) : (bus_mv - battery_mv);

  assign is_run     = (mode_request == hcs_pkg::MODE_RUN);
  assign is_charge  = (mode_request == hcs_pkg::MODE_CHARGE);
  assign drive_mode = (mode_request == hcs_pkg::MODE_START) || is_run;

  always_comb begin
    res                  = '0;
    res.held_state       = held_state;
    case (held_state)
      hcs_pkg::ST_DRV_PRE, hcs_pkg::ST_CHG_PRE: begin
        res.air_neg_closed   = 1'b1;
        res.precharge_closed = 1'b1;
      end
      hcs_pkg::ST_DRV_PREOK, hcs_pkg::ST_CHG_PREOK: begin
        res.air_pos_closed   = 1'b1;
        res.air_neg_closed   = 1'b1;
        res.precharge_closed = 1'b1;
      end
      hcs_pkg::ST_DRIVE, hcs_pkg::ST_TRICKLE, hcs_pkg::ST_CC, hcs_pkg::ST_CV: begin
        res.air_pos_closed = 1'b1;
        res.air_neg_closed = 1'b1;
      end
      hcs_pkg::ST_CLEAR: begin
        res.discharge_closed = 1'b1;
        res.clear_fault      = 1'b1;
        res.clear_error_reg  = 1'b1;
      end
      // error, discharge, standby, unknown and unused codes: safe set
      default: begin
        res.discharge_closed = 1'b1;
      end
    endcase
    res.next_state = nxt;
  end

  always_comb begin
    nxt = hcs_pkg::ST_UNKNOWN;
    if (error_active) begin
      nxt = hcs_pkg::ST_ERROR;
    end else begin
      case (held_state)
        hcs_pkg::ST_DISCHARGE: begin
          nxt = (bus_mv < cfg.discharged_limit_mv) ? hcs_pkg::ST_STANDBY
                                                   : hcs_pkg::ST_DISCHARGE;
        end
        hcs_pkg::ST_STANDBY: begin
          if (mode_request == hcs_pkg::MODE_START) nxt = hcs_pkg::ST_DRV_PRE;
          else if (is_charge)                      nxt = hcs_pkg::ST_CHG_PRE;
          else                                     nxt = hcs_pkg::ST_STANDBY;
        end
        hcs_pkg::ST_DRV_PRE: begin
          if (!drive_mode) nxt = hcs_pkg::ST_DISCHARGE;
          else if (diff < cfg.drive_match_mv && bus_mv > cfg.drive_min_bus_mv)
            nxt = hcs_pkg::ST_DRV_PREOK;
          else nxt = hcs_pkg::ST_DRV_PRE;
        end
        hcs_pkg::ST_DRV_PREOK: begin
          if (!drive_mode) nxt = hcs_pkg::ST_DISCHARGE;
          else if (is_run && diff < cfg.drive_match_mv) nxt = hcs_pkg::ST_DRIVE;
          else nxt = hcs_pkg::ST_DRV_PREOK;
        end
        hcs_pkg::ST_DRIVE: begin
          nxt = is_run ? hcs_pkg::ST_DRIVE : hcs_pkg::ST_DISCHARGE;
        end
        hcs_pkg::ST_CHG_PRE: begin
          if (!is_charge) nxt = hcs_pkg::ST_DISCHARGE;
          else if (diff < cfg.charge_match_mv) nxt = hcs_pkg::ST_CHG_PREOK;
          else nxt = hcs_pkg::ST_CHG_PRE;
        end
        hcs_pkg::ST_CHG_PREOK: begin
          if (!is_charge) nxt = hcs_pkg::ST_DISCHARGE;
          else if (diff < cfg.charge_close_mv) nxt = hcs_pkg::ST_TRICKLE;
          else nxt = hcs_pkg::ST_CHG_PREOK;
        end
        hcs_pkg::ST_TRICKLE: begin
          if (!is_charge) nxt = hcs_pkg::ST_DISCHARGE;
          else if (min_cell_mv >= cfg.trickle_exit_cell_mv) nxt = hcs_pkg::ST_CC;
          else nxt = hcs_pkg::ST_TRICKLE;
        end
        hcs_pkg::ST_CC: begin
          if (!is_charge) nxt = hcs_pkg::ST_DISCHARGE;
          else if (max_cell_mv >= cfg.cc_exit_cell_mv) nxt = hcs_pkg::ST_CV;
          else nxt = hcs_pkg::ST_CC;
        end
        hcs_pkg::ST_CV: begin
          nxt = (!is_charge || min_cell_mv >= cfg.cv_done_cell_mv) ? hcs_pkg::ST_DISCHARGE
                                                                   : hcs_pkg::ST_CV;
        end
        hcs_pkg::ST_ERROR: begin
          nxt = (mode_request == hcs_pkg::MODE_ACK) ? hcs_pkg::ST_CLEAR : hcs_pkg::ST_ERROR;
        end
        hcs_pkg::ST_CLEAR: begin
          nxt = (mode_request == hcs_pkg::MODE_IDLE && bus_mv < cfg.discharged_limit_mv)
                ? hcs_pkg::ST_STANDBY : hcs_pkg::ST_CLEAR;
        end
        // unknown state and unused codes stay unknown until an error
        default: begin
          nxt = hcs_pkg::ST_UNKNOWN;
        end
      endcase
    end
  end

endmodule

// ===== sv/hcs_checker.sv =====
// ----------------------------------------------------------------------------
// hcs_checker
// port-level checks on the sequencer result stream
// ----------------------------------------------------------------------------
`include "hv_contactor_charge_sequencer_core_defines.svh"

module hcs_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [hcs_pkg::ST_W-1:0] out_held_state,
  input logic [hcs_pkg::ST_W-1:0] out_next_state,
  input logic                     out_air_pos_closed,
  input logic                     out_discharge_closed,
  input logic                     out_clear_fault,
  input logic                     out_clear_error_reg
);

  logic [hcs_pkg::ST_W-1:0] last_next_r;
  logic                     out_acc;

  assign out_acc = out_valid && !out_stall;

  // next state of the last delivered item, error after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_next_r <= hcs_pkg::ST_ERROR;
    end else if (out_acc) begin
      last_next_r <= out_next_state;
    end
  end

  // each result starts from where the previous one left off
  `HCS_ASSERT_IMP(a_state_chain, clk, rst_n, out_valid, out_held_state == last_next_r)

  // clear pulses only in the clear error state, with discharge closed
  `HCS_ASSERT_IMP(a_clear_state, clk, rst_n, out_valid && (out_clear_fault || out_clear_error_reg),
    out_held_state == hcs_pkg::ST_CLEAR && out_discharge_closed && out_clear_fault == out_clear_error_reg)

  // main positive contactor never closed together with the discharge relay
  `HCS_ASSERT_IMP(a_pos_vs_dis, clk, rst_n, out_valid && out_air_pos_closed, !out_discharge_closed)

  // a stalled result holds
  `HCS_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_held_state) && $stable(out_next_state))

endmodule

bind hv_contactor_charge_sequencer_core hcs_checker u_hcs_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_held_state       (out_held_state),
  .out_next_state       (out_next_state),
  .out_air_pos_closed   (out_air_pos_closed),
  .out_discharge_closed (out_discharge_closed),
  .out_clear_fault      (out_clear_fault),
  .out_clear_error_reg  (out_clear_error_reg)
);

// ===== dv/hv_contactor_charge_sequencer_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hv_contactor_charge_sequencer_core_checker
// follows threshold writes and accepted items on the input channel, works
// out the step each item should produce and matches it against every
// accepted result in order; counts mismatches and outstanding results
// ----------------------------------------------------------------------------
module hv_contactor_charge_sequencer_core_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [hcs_pkg::IDX_W-1:0]  cfg_idx,
  input  logic [hcs_pkg::HV_W-1:0]   cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_error_active,
  input  logic [hcs_pkg::MODE_W-1:0] in_mode_request,
  input  logic [hcs_pkg::HV_W-1:0]   in_bus_mv,
  input  logic [hcs_pkg::HV_W-1:0]   in_battery_mv,
  input  logic [hcs_pkg::CELL_W-1:0] in_min_cell_mv,
  input  logic [hcs_pkg::CELL_W-1:0] in_max_cell_mv,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [hcs_pkg::ST_W-1:0]   out_held_state,
  input  logic [hcs_pkg::ST_W-1:0]   out_next_state,
  input  logic                       out_air_pos_closed,
  input  logic                       out_air_neg_closed,
  input  logic                       out_precharge_closed,
  input  logic                       out_discharge_closed,
  input  logic                       out_clear_fault,
  input  logic                       out_clear_error_reg,
  output int unsigned                fail_count,
  output int unsigned                pending
);

  hcs_pkg::cfg_regs_t       limits;
  logic [hcs_pkg::ST_W-1:0] seq_state;
  hcs_pkg::step_res_t       expected_steps[$];

  // relay levels for the held state, then the state the item moves it to
  function automatic hcs_pkg::step_res_t advance_sequencer(
    input logic [hcs_pkg::ST_W-1:0]   held,
    input hcs_pkg::cfg_regs_t         lim,
    input logic                       err,
    input logic [hcs_pkg::MODE_W-1:0] mode,
    input logic [hcs_pkg::HV_W-1:0]   bus,
    input logic [hcs_pkg::HV_W-1:0]   batt,
    input logic [hcs_pkg::CELL_W-1:0] cmin,
    input logic [hcs_pkg::CELL_W-1:0] cmax
  );
    hcs_pkg::step_res_t       r;
    logic [hcs_pkg::HV_W-1:0] gap;
    logic                     drive_req;
    r = '0;
    r.held_state = held;
    // exact difference, no wrap
    gap = (batt >= bus) ? batt - bus : bus - batt;
    drive_req = (mode == hcs_pkg::MODE_START) || (mode == hcs_pkg::MODE_RUN);

    case (held)
      hcs_pkg::ST_DRV_PRE, hcs_pkg::ST_CHG_PRE: begin
        r.air_neg_closed   = 1'b1;
        r.precharge_closed = 1'b1;
      end
      hcs_pkg::ST_DRV_PREOK, hcs_pkg::ST_CHG_PREOK: begin
        r.air_pos_closed   = 1'b1;
        r.air_neg_closed   = 1'b1;
        r.precharge_closed = 1'b1;
      end
      hcs_pkg::ST_DRIVE, hcs_pkg::ST_TRICKLE, hcs_pkg::ST_CC, hcs_pkg::ST_CV: begin
        r.air_pos_closed = 1'b1;
        r.air_neg_closed = 1'b1;
      end
      hcs_pkg::ST_CLEAR: begin
        r.discharge_closed = 1'b1;
        r.clear_fault      = 1'b1;
        r.clear_error_reg  = 1'b1;
      end
      default: r.discharge_closed = 1'b1;
    endcase

    if (err) begin
      r.next_state = hcs_pkg::ST_ERROR;
    end else begin
      case (held)
        hcs_pkg::ST_DISCHARGE:
          r.next_state = (bus < lim.discharged_limit_mv) ? hcs_pkg::ST_STANDBY
                                                         : hcs_pkg::ST_DISCHARGE;
        hcs_pkg::ST_STANDBY: begin
          if (mode == hcs_pkg::MODE_START) r.next_state = hcs_pkg::ST_DRV_PRE;
          else if (mode == hcs_pkg::MODE_CHARGE) r.next_state = hcs_pkg::ST_CHG_PRE;
          else r.next_state = hcs_pkg::ST_STANDBY;
        end
        hcs_pkg::ST_DRV_PRE: begin
          if (!drive_req) r.next_state = hcs_pkg::ST_DISCHARGE;
          else if (gap < lim.drive_match_mv && bus > lim.drive_min_bus_mv)
            r.next_state = hcs_pkg::ST_DRV_PREOK;
          else r.next_state = hcs_pkg::ST_DRV_PRE;
        end
        hcs_pkg::ST_DRV_PREOK: begin
          if (!drive_req) r.next_state = hcs_pkg::ST_DISCHARGE;
          else if (mode == hcs_pkg::MODE_RUN && gap < lim.drive_match_mv)
            r.next_state = hcs_pkg::ST_DRIVE;
          else r.next_state = hcs_pkg::ST_DRV_PREOK;
        end
        hcs_pkg::ST_DRIVE:
          r.next_state = (mode != hcs_pkg::MODE_RUN) ? hcs_pkg::ST_DISCHARGE
                                                     : hcs_pkg::ST_DRIVE;
        hcs_pkg::ST_CHG_PRE: begin
          if (mode != hcs_pkg::MODE_CHARGE) r.next_state = hcs_pkg::ST_DISCHARGE;
          else if (gap < lim.charge_match_mv) r.next_state = hcs_pkg::ST_CHG_PREOK;
          else r.next_state = hcs_pkg::ST_CHG_PRE;
        end
        hcs_pkg::ST_CHG_PREOK: begin
          if (mode != hcs_pkg::MODE_CHARGE) r.next_state = hcs_pkg::ST_DISCHARGE;
          else if (gap < lim.charge_close_mv) r.next_state = hcs_pkg::ST_TRICKLE;
          else r.next_state = hcs_pkg::ST_CHG_PREOK;
        end
        hcs_pkg::ST_TRICKLE: begin
          if (mode != hcs_pkg::MODE_CHARGE) r.next_state = hcs_pkg::ST_DISCHARGE;
          else if (cmin >= lim.trickle_exit_cell_mv) r.next_state = hcs_pkg::ST_CC;
          else r.next_state = hcs_pkg::ST_TRICKLE;
        end
        hcs_pkg::ST_CC: begin
          if (mode != hcs_pkg::MODE_CHARGE) r.next_state = hcs_pkg::ST_DISCHARGE;
          else if (cmax >= lim.cc_exit_cell_mv) r.next_state = hcs_pkg::ST_CV;
          else r.next_state = hcs_pkg::ST_CC;
        end
        hcs_pkg::ST_CV:
          r.next_state = (mode != hcs_pkg::MODE_CHARGE || cmin >= lim.cv_done_cell_mv) ?
                         hcs_pkg::ST_DISCHARGE : hcs_pkg::ST_CV;
        hcs_pkg::ST_ERROR:
          r.next_state = (mode == hcs_pkg::MODE_ACK) ? hcs_pkg::ST_CLEAR
                                                     : hcs_pkg::ST_ERROR;
        hcs_pkg::ST_CLEAR:
          r.next_state = (mode == hcs_pkg::MODE_IDLE && bus < lim.discharged_limit_mv) ?
                         hcs_pkg::ST_STANDBY : hcs_pkg::ST_CLEAR;
        // unknown and the unused codes only leave on an error
        default: r.next_state = hcs_pkg::ST_UNKNOWN;
      endcase
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    hcs_pkg::step_res_t want;
    if (!rst_n) begin
      limits = {hcs_pkg::RST_DISCHARGED_LIMIT, hcs_pkg::RST_DRIVE_MATCH,
                hcs_pkg::RST_DRIVE_MIN_BUS, hcs_pkg::RST_CHARGE_MATCH,
                hcs_pkg::RST_CHARGE_CLOSE, hcs_pkg::RST_TRICKLE_EXIT,
                hcs_pkg::RST_CC_EXIT, hcs_pkg::RST_CV_DONE};
      seq_state = hcs_pkg::ST_ERROR;
      expected_steps.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          hcs_pkg::REG_DISCHARGED_LIMIT: limits.discharged_limit_mv = cfg_data;
          hcs_pkg::REG_DRIVE_MATCH:      limits.drive_match_mv = cfg_data;
          hcs_pkg::REG_DRIVE_MIN_BUS:    limits.drive_min_bus_mv = cfg_data;
          hcs_pkg::REG_CHARGE_MATCH:     limits.charge_match_mv = cfg_data;
          hcs_pkg::REG_CHARGE_CLOSE:     limits.charge_close_mv = cfg_data;
          hcs_pkg::REG_TRICKLE_EXIT:
            limits.trickle_exit_cell_mv = cfg_data[hcs_pkg::CELL_W-1:0];
          hcs_pkg::REG_CC_EXIT:
            limits.cc_exit_cell_mv = cfg_data[hcs_pkg::CELL_W-1:0];
          hcs_pkg::REG_CV_DONE:
            limits.cv_done_cell_mv = cfg_data[hcs_pkg::CELL_W-1:0];
          default: ;
        endcase
      end

      // an item's result never leaves at the edge that accepts it, so check before queueing
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          flag_mismatch("result with no item waiting, held_state", 32'(out_held_state), 0);
        end else begin
          want = expected_steps.pop_front();
          if (out_held_state !== want.held_state)
            flag_mismatch("held_state", 32'(out_held_state), 32'(want.held_state));
          if (out_next_state !== want.next_state)
            flag_mismatch("next_state", 32'(out_next_state), 32'(want.next_state));
          if (out_air_pos_closed !== want.air_pos_closed)
            flag_mismatch("air_pos_closed", 32'(out_air_pos_closed),
                          32'(want.air_pos_closed));
          if (out_air_neg_closed !== want.air_neg_closed)
            flag_mismatch("air_neg_closed", 32'(out_air_neg_closed),
                          32'(want.air_neg_closed));
          if (out_precharge_closed !== want.precharge_closed)
            flag_mismatch("precharge_closed", 32'(out_precharge_closed),
                          32'(want.precharge_closed));
          if (out_discharge_closed !== want.discharge_closed)
            flag_mismatch("discharge_closed", 32'(out_discharge_closed),
                          32'(want.discharge_closed));
          if (out_clear_fault !== want.clear_fault)
            flag_mismatch("clear_fault", 32'(out_clear_fault), 32'(want.clear_fault));
          if (out_clear_error_reg !== want.clear_error_reg)
            flag_mismatch("clear_error_reg", 32'(out_clear_error_reg),
                          32'(want.clear_error_reg));
        end
      end

      if (in_valid && !in_stall) begin
        want = advance_sequencer(seq_state, limits, in_error_active, in_mode_request,
                                 in_bus_mv, in_battery_mv, in_min_cell_mv, in_max_cell_mv);
        expected_steps.push_back(want);
        seq_state = want.next_state;
      end
      pending = expected_steps.size();
    end
  end

endmodule

// ===== dv/hv_contactor_charge_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hv_contactor_charge_sequencer_core_tb
// drives sequencer ticks through the block: a directed walk through every
// state but unknown, then drive and charge sequences with random content
// and noise under several threshold settings, random gaps, result stalls
// ----------------------------------------------------------------------------
module hv_contactor_charge_sequencer_core_tb;

  localparam int unsigned HV_MAX      = (1 << hcs_pkg::HV_W) - 1;
  localparam int unsigned CELL_MAX    = (1 << hcs_pkg::CELL_W) - 1;
  localparam int unsigned IDLE_PCT    = 36;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 4;

  typedef logic [hcs_pkg::HV_W-1:0]                hv_t;
  typedef logic [hcs_pkg::CELL_W-1:0]              cell_t;
  typedef logic [hcs_pkg::MODE_W-1:0]              mode_t;
  typedef logic [hcs_pkg::HV_W-hcs_pkg::CELL_W-1:0] spare_t;

  // request codes that match no transition
  localparam mode_t MODE_NONE5 = 3'd5;
  localparam mode_t MODE_NONE6 = 3'd6;
  localparam mode_t MODE_NONE7 = 3'd7;

  typedef struct packed {
    logic  error_active;
    mode_t mode_request;
    hv_t   bus_mv;
    hv_t   battery_mv;
    cell_t min_cell_mv;
    cell_t max_cell_mv;
  } tick_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [hcs_pkg::IDX_W-1:0] cfg_idx = '0;
  hv_t                       cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_error_active = 1'b0;
  mode_t                     in_mode_request = '0;
  hv_t                       in_bus_mv = '0;
  hv_t                       in_battery_mv = '0;
  cell_t                     in_min_cell_mv = '0;
  cell_t                     in_max_cell_mv = '0;
  logic                      out_stall = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic [hcs_pkg::ST_W-1:0]  out_held_state;
  logic [hcs_pkg::ST_W-1:0]  out_next_state;
  logic                      out_air_pos_closed;
  logic                      out_air_neg_closed;
  logic                      out_precharge_closed;
  logic                      out_discharge_closed;
  logic                      out_clear_fault;
  logic                      out_clear_error_reg;

  logic                      calm = 1'b0;
  hcs_pkg::cfg_regs_t        limits;
  int unsigned               ticks_sent = 0;
  int unsigned               cycle_count = 0;
  int unsigned               fail_count;
  int unsigned               pending;

  hv_contactor_charge_sequencer_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_error_active(in_error_active), .in_mode_request(in_mode_request),
    .in_bus_mv(in_bus_mv), .in_battery_mv(in_battery_mv),
    .in_min_cell_mv(in_min_cell_mv), .in_max_cell_mv(in_max_cell_mv),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_held_state(out_held_state), .out_next_state(out_next_state),
    .out_air_pos_closed(out_air_pos_closed), .out_air_neg_closed(out_air_neg_closed),
    .out_precharge_closed(out_precharge_closed),
    .out_discharge_closed(out_discharge_closed),
    .out_clear_fault(out_clear_fault), .out_clear_error_reg(out_clear_error_reg)
  );

  hv_contactor_charge_sequencer_core_checker seq_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_error_active(in_error_active), .in_mode_request(in_mode_request),
    .in_bus_mv(in_bus_mv), .in_battery_mv(in_battery_mv),
    .in_min_cell_mv(in_min_cell_mv), .in_max_cell_mv(in_max_cell_mv),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_held_state(out_held_state), .out_next_state(out_next_state),
    .out_air_pos_closed(out_air_pos_closed), .out_air_neg_closed(out_air_neg_closed),
    .out_precharge_closed(out_precharge_closed),
    .out_discharge_closed(out_discharge_closed),
    .out_clear_fault(out_clear_fault), .out_clear_error_reg(out_clear_error_reg),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // present one item, holding it until the block takes it
  task automatic send_tick(input tick_t t);
    logic held_off;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_error_active <= t.error_active;
    in_mode_request <= t.mode_request;
    in_bus_mv       <= t.bus_mv;
    in_battery_mv   <= t.battery_mv;
    in_min_cell_mv  <= t.min_cell_mv;
    in_max_cell_mv  <= t.max_cell_mv;
    do begin
      @(negedge clk);
      held_off = in_stall;
      @(posedge clk);
    end while (held_off);
    ticks_sent++;
  endtask

  task automatic poke(input logic err, input mode_t mode,
                      input hv_t bus, input hv_t batt,
                      input cell_t cmin, input cell_t cmax);
    send_tick({err, mode, bus, batt, cmin, cmax});
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic load_thresholds(input hcs_pkg::cfg_regs_t v);
    spare_t junk;
    cfg_we   <= 1'b1;
    cfg_idx  <= hcs_pkg::REG_DISCHARGED_LIMIT;
    cfg_data <= v.discharged_limit_mv;
    @(posedge clk);
    cfg_idx  <= hcs_pkg::REG_DRIVE_MATCH;
    cfg_data <= v.drive_match_mv;
    @(posedge clk);
    cfg_idx  <= hcs_pkg::REG_DRIVE_MIN_BUS;
    cfg_data <= v.drive_min_bus_mv;
    @(posedge clk);
    cfg_idx  <= hcs_pkg::REG_CHARGE_MATCH;
    cfg_data <= v.charge_match_mv;
    @(posedge clk);
    cfg_idx  <= hcs_pkg::REG_CHARGE_CLOSE;
    cfg_data <= v.charge_close_mv;
    @(posedge clk);
    // cell registers are narrower, so spare upper bits must be dropped
    junk = spare_t'($urandom);
    cfg_idx  <= hcs_pkg::REG_TRICKLE_EXIT;
    cfg_data <= {junk, v.trickle_exit_cell_mv};
    @(posedge clk);
    junk = spare_t'($urandom);
    cfg_idx  <= hcs_pkg::REG_CC_EXIT;
    cfg_data <= {junk, v.cc_exit_cell_mv};
    @(posedge clk);
    junk = spare_t'($urandom);
    cfg_idx  <= hcs_pkg::REG_CV_DONE;
    cfg_data <= {junk, v.cv_done_cell_mv};
    @(posedge clk);
    cfg_we <= 1'b0;
    limits = v;
  endtask

  // a value on the chosen side of a threshold, often right at the boundary
  function automatic int unsigned pick_side(input int unsigned thr, input int unsigned top,
                                            input bit below);
    if (below) begin
      if (thr == 0) return 0;
      if ($urandom_range(1)) return thr - 1 - $urandom_range(thr - 1 < 3 ? thr - 1 : 3);
      return $urandom_range(thr - 1);
    end
    if (thr > top) return top;
    if ($urandom_range(1)) return thr + $urandom_range(top - thr < 3 ? top - thr : 3);
    return $urandom_range(top, thr);
  endfunction

  // bus and battery with their gap on one side of a threshold, bus from a floor
  function automatic logic [2*hcs_pkg::HV_W-1:0] pick_rails(input int unsigned gap_thr,
                                                            input bit close,
                                                            input int unsigned floor_mv);
    int unsigned gap;
    int unsigned lo;
    int unsigned bus;
    int unsigned batt;
    gap = pick_side(gap_thr, HV_MAX, close);
    lo  = (floor_mv > HV_MAX) ? HV_MAX : floor_mv;
    if ($urandom_range(1)) bus = lo + $urandom_range(HV_MAX - lo < 2 ? HV_MAX - lo : 2);
    else bus = $urandom_range(HV_MAX, lo);
    if (bus + gap <= HV_MAX && (bus < gap || $urandom_range(1))) batt = bus + gap;
    else if (bus >= gap) batt = bus - gap;
    else batt = HV_MAX;
    return {bus[hcs_pkg::HV_W-1:0], batt[hcs_pkg::HV_W-1:0]};
  endfunction

  function automatic tick_t any_tick();
    tick_t t;
    t.error_active = ($urandom_range(3) == 0);
    t.mode_request = mode_t'($urandom_range(7));
    t.bus_mv       = hv_t'($urandom_range(HV_MAX));
    t.battery_mv   = hv_t'($urandom_range(HV_MAX));
    t.min_cell_mv  = cell_t'($urandom_range(CELL_MAX));
    t.max_cell_mv  = cell_t'($urandom_range(CELL_MAX));
    return t;
  endfunction

  function automatic tick_t asking(input mode_t mode);
    tick_t t;
    t = any_tick();
    t.error_active = 1'b0;
    t.mode_request = mode;
    return t;
  endfunction

  // sequence items now and then become noise or raise an error
  task automatic push_tick(input tick_t t);
    if ($urandom_range(99) < 2) t = any_tick();
    else if ($urandom_range(99) == 0) t.error_active = 1'b1;
    send_tick(t);
  endtask

  // acknowledge any error, then idle with a low bus to reach standby
  task automatic wake_up();
    tick_t t;
    repeat ($urandom_range(2, 1)) begin
      t = asking(hcs_pkg::MODE_ACK);
      push_tick(t);
    end
    repeat ($urandom_range(3, 1)) begin
      t = asking(hcs_pkg::MODE_IDLE);
      t.bus_mv = hv_t'(pick_side(limits.discharged_limit_mv, HV_MAX,
                                 $urandom_range(99) < 85));
      push_tick(t);
    end
  endtask

  task automatic drive_trip();
    tick_t t;
    wake_up();
    t = asking(hcs_pkg::MODE_START);
    push_tick(t);
    repeat ($urandom_range(4, 1)) begin
      t = asking($urandom_range(1) ? hcs_pkg::MODE_START : hcs_pkg::MODE_RUN);
      {t.bus_mv, t.battery_mv} = pick_rails(limits.drive_match_mv, $urandom_range(99) < 80,
          ($urandom_range(99) < 80) ? limits.drive_min_bus_mv + 1 : 0);
      push_tick(t);
    end
    repeat ($urandom_range(3, 1)) begin
      t = asking(hcs_pkg::MODE_RUN);
      {t.bus_mv, t.battery_mv} = pick_rails(limits.drive_match_mv,
                                            $urandom_range(99) < 80, 0);
      push_tick(t);
    end
    repeat ($urandom_range(6)) begin
      t = asking(hcs_pkg::MODE_RUN);
      push_tick(t);
    end
    t = any_tick();
    t.error_active = ($urandom_range(4) == 0);
    push_tick(t);
  endtask

  task automatic charge_trip();
    tick_t t;
    wake_up();
    t = asking(hcs_pkg::MODE_CHARGE);
    push_tick(t);
    repeat ($urandom_range(3, 1)) begin
      t = asking(hcs_pkg::MODE_CHARGE);
      {t.bus_mv, t.battery_mv} = pick_rails(limits.charge_match_mv,
                                            $urandom_range(99) < 80, 0);
      push_tick(t);
    end
    repeat ($urandom_range(3, 1)) begin
      t = asking(hcs_pkg::MODE_CHARGE);
      {t.bus_mv, t.battery_mv} = pick_rails(limits.charge_close_mv,
                                            $urandom_range(99) < 80, 0);
      push_tick(t);
    end
    repeat ($urandom_range(4, 1)) begin
      t = asking(hcs_pkg::MODE_CHARGE);
      t.min_cell_mv = cell_t'(pick_side(limits.trickle_exit_cell_mv, CELL_MAX,
                                        $urandom_range(99) < 40));
      push_tick(t);
    end
    repeat ($urandom_range(4, 1)) begin
      t = asking(hcs_pkg::MODE_CHARGE);
      t.max_cell_mv = cell_t'(pick_side(limits.cc_exit_cell_mv, CELL_MAX,
                                        $urandom_range(99) < 40));
      push_tick(t);
    end
    repeat ($urandom_range(4, 1)) begin
      t = asking(hcs_pkg::MODE_CHARGE);
      t.min_cell_mv = cell_t'(pick_side(limits.cv_done_cell_mv, CELL_MAX,
                                        $urandom_range(99) < 70));
      push_tick(t);
    end
    t = any_tick();
    t.error_active = ($urandom_range(4) == 0);
    push_tick(t);
  endtask

  task automatic wander(input int unsigned goal);
    tick_t t;
    while (ticks_sent < goal) begin
      case ($urandom_range(9))
        0, 1, 2, 3: drive_trip();
        4, 5, 6, 7: charge_trip();
        default: repeat ($urandom_range(5, 1)) begin
          t = any_tick();
          send_tick(t);
        end
      endcase
    end
  endtask

  initial begin
    hcs_pkg::cfg_regs_t plan;
    limits = {hcs_pkg::RST_DISCHARGED_LIMIT, hcs_pkg::RST_DRIVE_MATCH,
              hcs_pkg::RST_DRIVE_MIN_BUS, hcs_pkg::RST_CHARGE_MATCH,
              hcs_pkg::RST_CHARGE_CLOSE, hcs_pkg::RST_TRICKLE_EXIT,
              hcs_pkg::RST_CC_EXIT, hcs_pkg::RST_CV_DONE};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk through every state but unknown at the reset thresholds
    poke(1'b1, hcs_pkg::MODE_ACK, hv_t'(HV_MAX), hv_t'(HV_MAX),
         cell_t'(CELL_MAX), cell_t'(CELL_MAX));
    poke(1'b0, MODE_NONE5, 0, 0, 0, 0);
    poke(1'b0, hcs_pkg::MODE_ACK, hv_t'(HV_MAX), 0, 0, cell_t'(CELL_MAX));
    poke(1'b0, MODE_NONE7, 0, 0, 0, 0);
    poke(1'b0, hcs_pkg::MODE_IDLE, 5000, 0, 0, 0);
    poke(1'b0, hcs_pkg::MODE_IDLE, 4999, 0, 0, 0);
    poke(1'b0, MODE_NONE6, 0, 0, 0, 0);
    poke(1'b0, hcs_pkg::MODE_START, 10000, 10000, 0, 0);
    poke(1'b0, hcs_pkg::MODE_RUN, 10001, 40001, 0, 0);
    poke(1'b0, hcs_pkg::MODE_START, 10001, 40000, 0, 0);
    poke(1'b0, hcs_pkg::MODE_START, 20000, 20000, 0, 0);
    poke(1'b0, hcs_pkg::MODE_RUN, 40000, 10001, 0, 0);
    poke(1'b0, hcs_pkg::MODE_RUN, hv_t'(HV_MAX), 0, 0, 0);
    poke(1'b0, hcs_pkg::MODE_IDLE, hv_t'(HV_MAX), hv_t'(HV_MAX), 0, 0);
    poke(1'b0, hcs_pkg::MODE_IDLE, 0, 0, 0, 0);
    poke(1'b0, hcs_pkg::MODE_CHARGE, 0, 0, 0, 0);
    // widest possible gap must not wrap
    poke(1'b0, hcs_pkg::MODE_CHARGE, 0, hv_t'(HV_MAX), 0, 0);
    poke(1'b0, hcs_pkg::MODE_CHARGE, 100000, 124999, 0, 0);
    poke(1'b0, hcs_pkg::MODE_CHARGE, 100000, 95001, 0, 0);
    poke(1'b0, hcs_pkg::MODE_CHARGE, 0, 0, 2999, 0);
    poke(1'b0, hcs_pkg::MODE_CHARGE, 0, 0, 3000, 0);
    poke(1'b0, hcs_pkg::MODE_CHARGE, 0, 0, 0, cell_t'(CELL_MAX));
    poke(1'b0, hcs_pkg::MODE_CHARGE, 0, 0, 4145, 0);
    poke(1'b1, hcs_pkg::MODE_IDLE, 0, 0, 0, 0);

    wander(350);
    settle();

    // moderate thresholds, and a long stretch with no gaps or stalls
    plan.discharged_limit_mv  = hv_t'($urandom_range(60000, 1000));
    plan.drive_match_mv       = hv_t'($urandom_range(100000, 1000));
    plan.drive_min_bus_mv     = hv_t'($urandom_range(400000, 1000));
    plan.charge_match_mv      = hv_t'($urandom_range(100000, 1000));
    plan.charge_close_mv      = hv_t'($urandom_range(20000, 100));
    plan.trickle_exit_cell_mv = cell_t'($urandom_range(3300, 2500));
    plan.cc_exit_cell_mv      = cell_t'($urandom_range(4300, 3800));
    plan.cv_done_cell_mv      = cell_t'($urandom_range(4300, 3800));
    load_thresholds(plan);
    calm <= 1'b1;
    wander(650);
    settle();
    calm <= 1'b0;

    plan = '0;
    load_thresholds(plan);
    wander(750);
    settle();

    plan = '1;
    load_thresholds(plan);
    wander(850);
    settle();

    plan.discharged_limit_mv  = hv_t'($urandom);
    plan.drive_match_mv       = hv_t'($urandom);
    plan.drive_min_bus_mv     = hv_t'($urandom);
    plan.charge_match_mv      = hv_t'($urandom);
    plan.charge_close_mv      = hv_t'($urandom);
    plan.trickle_exit_cell_mv = cell_t'($urandom);
    plan.cc_exit_cell_mv      = cell_t'($urandom);
    plan.cv_done_cell_mv      = cell_t'($urandom);
    load_thresholds(plan);
    wander(950);
    settle();

    plan = {hcs_pkg::RST_DISCHARGED_LIMIT, hcs_pkg::RST_DRIVE_MATCH,
            hcs_pkg::RST_DRIVE_MIN_BUS, hcs_pkg::RST_CHARGE_MATCH,
            hcs_pkg::RST_CHARGE_CLOSE, hcs_pkg::RST_TRICKLE_EXIT,
            hcs_pkg::RST_CC_EXIT, hcs_pkg::RST_CV_DONE};
    load_thresholds(plan);
    wander(1150);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/hcs_pkg.sv
sv/hcs_step.sv
sv/hv_contactor_charge_sequencer_core.sv
sv/hcs_checker.sv
dv/hv_contactor_charge_sequencer_core_checker.sv
dv/hv_contactor_charge_sequencer_core_tb.sv
